>>> design/hierarchical_bus_gain_mixer_defines.svh
// Assertion macros shared by the mixer modules.
// Needs nothing; included by the files that check their own logic.
`ifndef HIERARCHICAL_BUS_GAIN_MIXER_DEFINES_SVH
`define HIERARCHICAL_BUS_GAIN_MIXER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HBGM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define HBGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition never holds
`define HBGM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/hbgm_pkg.sv
// Types, constants and tables of the hierarchical bus gain mixer.
// Depends on nothing; used by every other design file but the macro header.
package hbgm_pkg;

   localparam int NUM_BUSES = 16;
   localparam int BUS_W     = $clog2(NUM_BUSES);
   localparam int GAIN_W    = 16;
   localparam int VOL_W     = 15;
   localparam int DUCK_W    = 16;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
   localparam logic [21:0] LOG2_10_OVER_20_Q24 = 22'd2786635;

   localparam logic [VOL_W-1:0] VOL_UNITY   = 15'd4096;
   localparam logic [VOL_W-1:0] VOL_REDUCED = 15'd3277;
   localparam logic [BUS_W-1:0] BUS_MASTER   = 4'd0;
   localparam logic [BUS_W-1:0] BUS_MUSIC    = 4'd5;
   localparam logic [BUS_W-1:0] BUS_AMBIENCE = 4'd12;

   localparam logic [BUS_W-1:0] BUS_PARENT [NUM_BUSES] = '{
      4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd5, 4'd5,
      4'd5, 4'd0, 4'd9, 4'd9, 4'd0, 4'd12, 4'd12, 4'd12
   };

   // SFX and Ambience subtrees
   localparam logic [NUM_BUSES-1:0] VACUUM_MASK = 16'b1111_0000_0001_1110;

   localparam logic [17:0] EXP2_TAB [17] = '{
      18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
      18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
      18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
   };

   typedef enum logic [2:0] {
      CMD_SET_VOLUME = 3'd0,
      CMD_SET_MUTE   = 3'd1,
      CMD_ADD_DUCK   = 3'd2,
      CMD_CLEAR_DUCK = 3'd3,
      CMD_QUERY      = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_ISSUE,
      ST_LOAD,
      ST_HOP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [VOL_W-1:0]         volume;
      logic                     mute;
      logic signed [DUCK_W-1:0] duck;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [BUS_W-1:0] rd_addr;
      logic             wr_en;
      logic [BUS_W-1:0] wr_addr;
      logic             clr_duck;
   } store_ctl_type;

   function automatic logic [VOL_W-1:0] reset_volume(input logic [BUS_W-1:0] b);
      logic [VOL_W-1:0] v;
      v = VOL_UNITY;
      if (b == BUS_MUSIC || b == BUS_AMBIENCE) begin
         v = VOL_REDUCED;
      end
      return v;
   endfunction

endpackage

>>> design/hbgm_if.sv
// Request and response channel interfaces of the mixer.
// Depends on hbgm_pkg for field widths.
interface hbgm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [2:0]                              cmd;
   logic [hbgm_pkg::BUS_W-1:0]              bus;
   logic signed [15:0]                      volume_in;
   logic                                    mute_in;
   logic signed [15:0]                      duck_delta;

   modport source (output valid, cmd, bus, volume_in, mute_in, duck_delta, input ready);
   modport sink (input valid, cmd, bus, volume_in, mute_in, duck_delta, output ready);
endinterface

interface hbgm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [hbgm_pkg::GAIN_W-1:0]             effective_gain;
   logic [hbgm_pkg::VOL_W-1:0]              stored_volume;
   logic                                    stored_mute;

   modport source (output valid, effective_gain, stored_volume, stored_mute, input ready);
   modport sink (input valid, effective_gain, stored_volume, stored_mute, output ready);
endinterface

>>> design/hbgm_store.sv
// Bus state memory: volume, mute and ducking per bus, with registered read data.
// Depends on hbgm_pkg and the assertion macro header.
`include "hierarchical_bus_gain_mixer_defines.svh"

module hbgm_store (
   input  logic                     clock,
   input  logic                     reset,
   input  hbgm_pkg::store_ctl_type  ctl,
   input  hbgm_pkg::entry_type      wr_data,
   output hbgm_pkg::entry_type      rd_entry
);

   hbgm_pkg::entry_type                   store_mem [hbgm_pkg::NUM_BUSES];
   hbgm_pkg::entry_type                   rdata_ff;
   logic [hbgm_pkg::BUS_W-1:0]            raddr_ff;
   logic [hbgm_pkg::NUM_BUSES-1:0]        vld_ff;
   logic [hbgm_pkg::NUM_BUSES-1:0]        vld_in;
   logic [hbgm_pkg::NUM_BUSES-1:0]        dvld_ff;
   logic [hbgm_pkg::NUM_BUSES-1:0]        dvld_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= store_mem[ctl.rd_addr];
         raddr_ff <= ctl.rd_addr;
      end
   end

   always_comb begin
      vld_in  = vld_ff;
      dvld_in = dvld_ff;
      if (ctl.clr_duck) begin
         dvld_in = '0;
      end
      if (ctl.wr_en) begin
         vld_in[ctl.wr_addr]  = 1'b1;
         dvld_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         dvld_ff <= '0;
      end else begin
         vld_ff  <= vld_in;
         dvld_ff <= dvld_in;
      end
   end

   // unwritten entries read as their reset values
   always_comb begin
      rd_entry.volume = vld_ff[raddr_ff] ? rdata_ff.volume : hbgm_pkg::reset_volume(raddr_ff);
      rd_entry.mute   = vld_ff[raddr_ff] ? rdata_ff.mute : 1'b0;
      rd_entry.duck   = dvld_ff[raddr_ff] ? rdata_ff.duck : '0;
   end

   `HBGM_ASSERT_NEVER(a_no_rw_collision, clock, reset, ctl.rd_en && ctl.wr_en && (ctl.rd_addr == ctl.wr_addr), "read and write of one entry in one cycle")
   `HBGM_ASSERT_NEVER(a_no_write_on_clear, clock, reset, ctl.wr_en && ctl.clr_duck, "write during duck clear")
   `HBGM_ASSERT_NEXT(a_clear_drops_duck, clock, reset, ctl.clr_duck, dvld_ff == '0, "duck valid bits survive clear")

endmodule

>>> design/hbgm_hop_unit.sv
// Per-bus gain step: volume multiply, then 10^(duck/20) via exp2 table.
// Five register stages; depends on hbgm_pkg.
module hbgm_hop_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [hbgm_pkg::GAIN_W-1:0]         g_in,
   input  hbgm_pkg::entry_type                 entry,
   output logic                                done,
   output logic [hbgm_pkg::GAIN_W-1:0]         g_out
);

   logic [3:0]                         vld_ff;
   logic                               done_ff;

   logic [30:0]                        s0_prodv_ff;
   logic signed [38:0]                 s0_e_ff;

   logic [hbgm_pkg::GAIN_W-1:0]        s1_g_ff;
   logic [hbgm_pkg::GAIN_W-1:0]        s1_g_in;
   logic [5:0]                         s1_ip_ff;
   logic [3:0]                         s1_idx_ff;
   logic [11:0]                        s1_rem_ff;
   logic [31:0]                        vsum;
   logic [38:0]                        t_val;
   logic [37:0]                        t_rnd;

   logic [hbgm_pkg::GAIN_W-1:0]        s2_g_ff;
   logic [5:0]                         s2_ip_ff;
   logic [16:0]                        s2_tlo_ff;
   logic [24:0]                        s2_dp_ff;
   logic [17:0]                        t_lo;
   logic [17:0]                        t_hi;
   logic [12:0]                        t_diff;

   logic [5:0]                         s3_ip_ff;
   logic [33:0]                        s3_prod_ff;
   logic [17:0]                        mant;

   logic [hbgm_pkg::GAIN_W-1:0]        g_out_ff;
   logic [hbgm_pkg::GAIN_W-1:0]        g_out_in;
   logic [3:0]                         lsh;
   logic [5:0]                         rsh;
   logic [49:0]                        wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[2:0], start};
         done_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      s0_prodv_ff <= 31'(g_in) * 31'(entry.volume);
      s0_e_ff     <= $signed({{23{entry.duck[15]}}, entry.duck})
                     * $signed({17'd0, hbgm_pkg::LOG2_10_OVER_20_Q24});
   end

   always_comb begin
      vsum    = {1'b0, s0_prodv_ff} + 32'd2048;
      s1_g_in = (vsum[31:28] != 4'd0) ? hbgm_pkg::GAIN_MAX : vsum[27:12];
      t_val   = 39'(s0_e_ff) + (39'd1 << 37);
      t_rnd   = t_val[37:0] + 38'd32768;
   end

   always_ff @(posedge clock) begin
      s1_g_ff   <= s1_g_in;
      s1_ip_ff  <= t_rnd[37:32];
      s1_idx_ff <= t_rnd[31:28];
      s1_rem_ff <= t_rnd[27:16];
   end

   always_comb begin
      t_lo   = hbgm_pkg::EXP2_TAB[{1'b0, s1_idx_ff}];
      t_hi   = hbgm_pkg::EXP2_TAB[{1'b0, s1_idx_ff} + 5'd1];
      t_diff = 13'(t_hi - t_lo);
   end

   always_ff @(posedge clock) begin
      s2_g_ff   <= s1_g_ff;
      s2_ip_ff  <= s1_ip_ff;
      s2_tlo_ff <= t_lo[16:0];
      s2_dp_ff  <= 25'(t_diff) * 25'(s1_rem_ff);
   end

   always_comb begin
      mant = 18'(s2_tlo_ff) + 18'((26'(s2_dp_ff) + 26'd2048) >> 12);
   end

   always_ff @(posedge clock) begin
      s3_ip_ff   <= s2_ip_ff;
      s3_prod_ff <= 34'(s2_g_ff) * 34'(mant);
   end

   // scale by 2^(n-16), n = ip - 32
   always_comb begin
      lsh  = '0;
      rsh  = '0;
      wide = '0;
      if (s3_ip_ff >= 6'd48) begin
         lsh  = 4'(s3_ip_ff - 6'd48);
         wide = 50'(s3_prod_ff) << lsh;
      end else begin
         rsh  = 6'd48 - s3_ip_ff;
         wide = (50'(s3_prod_ff) + (50'd1 << (rsh - 6'd1))) >> rsh;
      end
      g_out_in = (wide > 50'(hbgm_pkg::GAIN_MAX)) ? hbgm_pkg::GAIN_MAX : wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (vld_ff[3]) begin
         g_out_ff <= g_out_in;
      end
   end

   assign done  = done_ff;
   assign g_out = g_out_ff;

endmodule

>>> design/hierarchical_bus_gain_mixer.sv
// Hierarchical bus gain mixer top level: command sequencer and result register.
// Depends on hbgm_pkg, hbgm_if, hbgm_store, hbgm_hop_unit and the macro header.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid / ready    cmd, bus, volume_in, mute_in, duck_delta
//   rsp_chan  out  valid / ready    effective_gain, stored_volume, stored_mute
//   csr       in   csr_we           csr_wdata (vacuum mode)
//
// An item walks its path bus by bus from the addressed bus up to Master;
// a muted bus or a vacuumed subtree ends the walk early.
// Each bus costs one read of the state memory and the five stages of the hop unit.
// Reset clears the entry valid bits; every bus then reads its default state at once.
// One result waits in the output register while the next item is taken.
`include "hierarchical_bus_gain_mixer_defines.svh"

module hierarchical_bus_gain_mixer (
   input  logic         clock,
   input  logic         reset,
   hbgm_req_if.sink     req_chan,
   hbgm_rsp_if.source   rsp_chan,
   input  logic         csr_we,
   input  logic         csr_wdata
);

   hbgm_pkg::state_type                state_ff;
   hbgm_pkg::state_type                state_in;
   hbgm_pkg::cmd_type                  cmd_ff;
   logic [hbgm_pkg::BUS_W-1:0]         bus_ff;
   logic signed [15:0]                 vin_ff;
   logic                               mute_in_ff;
   logic signed [15:0]                 delta_ff;
   logic [hbgm_pkg::BUS_W-1:0]         cur_ff;
   logic [hbgm_pkg::BUS_W-1:0]         cur_in;
   logic [hbgm_pkg::GAIN_W-1:0]        gain_ff;
   logic [hbgm_pkg::GAIN_W-1:0]        gain_in;
   logic [hbgm_pkg::VOL_W-1:0]         sv_ff;
   logic [hbgm_pkg::VOL_W-1:0]         sv_in;
   logic                               sm_ff;
   logic                               sm_in;
   logic                               vacuum_ff;
   logic                               vacuum_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [hbgm_pkg::GAIN_W-1:0]        rsp_gain_ff;
   logic [hbgm_pkg::VOL_W-1:0]         rsp_vol_ff;
   logic                               rsp_mute_ff;
   logic                               load_out;

   hbgm_pkg::store_ctl_type            store_ctl;
   hbgm_pkg::entry_type                wr_entry;
   hbgm_pkg::entry_type                rd_entry;
   logic                               hop_start;
   logic                               hop_done;
   logic [hbgm_pkg::GAIN_W-1:0]        hop_gain;
   logic signed [16:0]                 duck_sum;

   hbgm_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .wr_data  (wr_entry),
      .rd_entry (rd_entry)
   );

   hbgm_hop_unit u_hop (
      .clock (clock),
      .reset (reset),
      .start (hop_start),
      .g_in  (gain_ff),
      .entry (rd_entry),
      .done  (hop_done),
      .g_out (hop_gain)
   );

   assign duck_sum = {rd_entry.duck[15], rd_entry.duck} + {delta_ff[15], delta_ff};

   always_comb begin
      state_in         = state_ff;
      cur_in           = cur_ff;
      gain_in          = gain_ff;
      sv_in            = sv_ff;
      sm_in            = sm_ff;
      store_ctl        = '0;
      wr_entry         = rd_entry;
      hop_start        = 1'b0;
      load_out         = 1'b0;
      req_chan.ready   = 1'b0;
      unique case (state_ff)
         hbgm_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               store_ctl.rd_en   = 1'b1;
               store_ctl.rd_addr = req_chan.bus;
               cur_in            = req_chan.bus;
               gain_in           = hbgm_pkg::GAIN_ONE;
               state_in          = hbgm_pkg::ST_UPDATE;
            end
         end
         hbgm_pkg::ST_UPDATE: begin
            store_ctl.wr_addr = bus_ff;
            unique case (cmd_ff)
               hbgm_pkg::CMD_SET_VOLUME: begin
                  wr_entry.volume = vin_ff[15] ? '0 : vin_ff[14:0];
                  store_ctl.wr_en = 1'b1;
               end
               hbgm_pkg::CMD_SET_MUTE: begin
                  wr_entry.mute   = mute_in_ff;
                  store_ctl.wr_en = 1'b1;
               end
               hbgm_pkg::CMD_ADD_DUCK: begin
                  if (duck_sum[16] != duck_sum[15]) begin
                     wr_entry.duck = duck_sum[16] ? 16'sh8000 : 16'sh7FFF;
                  end else begin
                     wr_entry.duck = duck_sum[15:0];
                  end
                  store_ctl.wr_en = 1'b1;
               end
               hbgm_pkg::CMD_CLEAR_DUCK: begin
                  store_ctl.clr_duck = 1'b1;
               end
               default: begin
               end
            endcase
            sv_in = wr_entry.volume;
            sm_in = wr_entry.mute;
            if (vacuum_ff && hbgm_pkg::VACUUM_MASK[bus_ff]) begin
               gain_in  = '0;
               state_in = hbgm_pkg::ST_DONE;
            end else begin
               state_in = hbgm_pkg::ST_ISSUE;
            end
         end
         hbgm_pkg::ST_ISSUE: begin
            // read after the write-back has landed
            store_ctl.rd_en   = 1'b1;
            store_ctl.rd_addr = cur_ff;
            state_in          = hbgm_pkg::ST_LOAD;
         end
         hbgm_pkg::ST_LOAD: begin
            if (rd_entry.mute) begin
               gain_in  = '0;
               state_in = hbgm_pkg::ST_DONE;
            end else begin
               hop_start         = 1'b1;
               store_ctl.rd_en   = 1'b1;
               store_ctl.rd_addr = hbgm_pkg::BUS_PARENT[cur_ff];
               state_in          = hbgm_pkg::ST_HOP;
            end
         end
         hbgm_pkg::ST_HOP: begin
            if (hop_done) begin
               gain_in = hop_gain;
               if (cur_ff == hbgm_pkg::BUS_MASTER) begin
                  state_in = hbgm_pkg::ST_DONE;
               end else begin
                  cur_in   = hbgm_pkg::BUS_PARENT[cur_ff];
                  state_in = hbgm_pkg::ST_LOAD;
               end
            end
         end
         hbgm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = hbgm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbgm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbgm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff     <= hbgm_pkg::cmd_type'(req_chan.cmd);
         bus_ff     <= req_chan.bus;
         vin_ff     <= req_chan.volume_in;
         mute_in_ff <= req_chan.mute_in;
         delta_ff   <= req_chan.duck_delta;
      end
      cur_ff  <= cur_in;
      gain_ff <= gain_in;
      sv_ff   <= sv_in;
      sm_ff   <= sm_in;
   end

   assign vacuum_in = csr_we ? csr_wdata : vacuum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vacuum_ff <= 1'b0;
      end else begin
         vacuum_ff <= vacuum_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_gain_ff <= gain_ff;
         rsp_vol_ff  <= sv_ff;
         rsp_mute_ff <= sm_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.effective_gain = rsp_gain_ff;
   assign rsp_chan.stored_volume  = rsp_vol_ff;
   assign rsp_chan.stored_mute    = rsp_mute_ff;

   `HBGM_ASSERT_NEXT(a_accept_to_update, clock, reset, req_chan.valid && req_chan.ready, state_ff == hbgm_pkg::ST_UPDATE, "transfer did not start an update")
   `HBGM_ASSERT_SAME(a_hop_done_in_hop, clock, reset, hop_done, state_ff == hbgm_pkg::ST_HOP, "hop result outside hop state")
   `HBGM_ASSERT_SAME(a_muted_gives_zero, clock, reset, (state_ff == hbgm_pkg::ST_DONE) && sm_ff, gain_ff == '0, "muted bus with nonzero gain")

endmodule

>>> tb/sv/hbgm_gain_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the bus gain mixer: mirrors the bus tables and the vacuum register,
// predicts each bus report and compares it with the response channel transfer.
// Depends on hbgm_pkg and the channel interfaces in hbgm_if.
module hbgm_gain_checker (
   input  logic clock,
   input  logic reset,
   hbgm_req_if  req_mon,
   hbgm_rsp_if  rsp_mon,
   input  logic csr_we,
   input  logic csr_wdata,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      logic [15:0] gain;
      logic [14:0] volume;
      logic        mute;
   } bus_report_type;

   localparam logic [3:0] UPLINK [16] = '{
      4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd5, 4'd5,
      4'd5, 4'd0, 4'd9, 4'd9, 4'd0, 4'd12, 4'd12, 4'd12
   };
   localparam logic [15:0] SILENCED_BY_VACUUM = 16'hF01E;
   localparam logic [17:0] POW2_FRAC [17] = '{
      18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
      18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
      18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
   };

   logic [14:0]        vol_mirror  [16];
   logic               mute_mirror [16];
   logic signed [15:0] duck_mirror [16];
   logic               vacuum_mirror;
   bus_report_type     report_q [$];
   int                 fails;

   function automatic logic [63:0] clip_gain(input logic [63:0] g);
      return (g > 64'd65535) ? 64'd65535 : g;
   endfunction

   function automatic logic [63:0] scale_by_duck(input logic [63:0] g,
                                                 input logic signed [15:0] duck);
      longint      e;
      logic [63:0] u;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] m;
      logic [63:0] prod;
      int          n;
      int          s;
      e = longint'(duck) * 64'sd2786635;
      u = (64'(e) + (64'd32 << 32) + 64'd32768) >> 16;
      n = int'(u >> 16) - 32;
      lo = 64'(POW2_FRAC[int'(u[15:12])]);
      hi = 64'(POW2_FRAC[int'(u[15:12]) + 1]);
      m = lo + (((hi - lo) * 64'(u[11:0]) + 64'd2048) >> 12);
      prod = g * m;
      s = 16 - n;
      if (s <= 0) return clip_gain(prod << (-s));
      return clip_gain((prod + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic logic [15:0] path_gain(input logic [3:0] bus);
      logic [63:0] g;
      logic [3:0]  cur;
      g = 64'd4096;
      cur = bus;
      if (vacuum_mirror && SILENCED_BY_VACUUM[bus]) return '0;
      for (int hop = 0; hop < 3; hop++) begin
         if (mute_mirror[cur]) return '0;
         g = clip_gain((g * 64'(vol_mirror[cur]) + 64'd2048) >> 12);
         if (duck_mirror[cur] != 0) g = scale_by_duck(g, duck_mirror[cur]);
         if (cur == 4'd0) break;
         cur = UPLINK[cur];
      end
      return g[15:0];
   endfunction

   function automatic void take_command(input logic [2:0] cmd, input logic [3:0] bus,
                                        input logic signed [15:0] vol, input logic mute,
                                        input logic signed [15:0] delta);
      int sum;
      case (cmd)
         hbgm_pkg::CMD_SET_VOLUME: vol_mirror[bus] = vol[15] ? 15'd0 : vol[14:0];
         hbgm_pkg::CMD_SET_MUTE:   mute_mirror[bus] = mute;
         hbgm_pkg::CMD_ADD_DUCK: begin
            sum = int'(duck_mirror[bus]) + int'(delta);
            if (sum > 32767) sum = 32767;
            else if (sum < -32768) sum = -32768;
            duck_mirror[bus] = 16'(sum);
         end
         hbgm_pkg::CMD_CLEAR_DUCK: begin
            for (int i = 0; i < 16; i++) duck_mirror[i] = '0;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      bus_report_type want;
      logic           bad;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            vol_mirror[i]  = 15'd4096;
            mute_mirror[i] = 1'b0;
            duck_mirror[i] = '0;
         end
         vol_mirror[5]  = 15'd3277;
         vol_mirror[12] = 15'd3277;
         vacuum_mirror = 1'b0;
         report_q.delete();
         fails = 0;
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (csr_we) vacuum_mirror = csr_wdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (report_q.size() == 0) begin
               $display("%0t: unexpected report, expected none, actual gain=%0d volume=%0d mute=%0d",
                        $time, rsp_mon.effective_gain, rsp_mon.stored_volume,
                        rsp_mon.stored_mute);
               fails++;
            end else begin
               want = report_q.pop_front();
               bad = 1'b0;
               if (rsp_mon.effective_gain !== want.gain) begin
                  $display("%0t: effective_gain expected %0d actual %0d",
                           $time, want.gain, rsp_mon.effective_gain);
                  bad = 1'b1;
               end
               if (rsp_mon.stored_volume !== want.volume) begin
                  $display("%0t: stored_volume expected %0d actual %0d",
                           $time, want.volume, rsp_mon.stored_volume);
                  bad = 1'b1;
               end
               if (rsp_mon.stored_mute !== want.mute) begin
                  $display("%0t: stored_mute expected %0d actual %0d",
                           $time, want.mute, rsp_mon.stored_mute);
                  bad = 1'b1;
               end
               if (bad) fails++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            take_command(req_mon.cmd, req_mon.bus, req_mon.volume_in, req_mon.mute_in,
                         req_mon.duck_delta);
            want.gain   = path_gain(req_mon.bus);
            want.volume = vol_mirror[req_mon.bus];
            want.mute   = mute_mirror[req_mon.bus];
            report_q.push_back(want);
         end
         fail_count  <= fails;
         outstanding <= report_q.size();
      end
   end

endmodule

>>> tb/sv/tb_hierarchical_bus_gain_mixer.sv
`timescale 1ns / 100ps
// Top of the bus gain mixer testbench: clock, reset, command stimulus and verdict.
// Depends on hbgm_pkg, hbgm_if, the mixer top level and hbgm_gain_checker.
module tb_hierarchical_bus_gain_mixer;

   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int SEGMENT_ITEMS = 238;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;
   int   fail_count;
   int   outstanding;
   int   send_gap_pct;
   int   take_stall_pct;

   hbgm_req_if req_chan ();
   hbgm_rsp_if rsp_chan ();

   hierarchical_bus_gain_mixer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   hbgm_gain_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= take_stall_pct);
   end

   task automatic issue_command(input logic [2:0] cmd, input logic [3:0] bus,
                                input logic signed [15:0] vol, input logic mute,
                                input logic signed [15:0] delta);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.bus        <= bus;
      req_chan.volume_in  <= vol;
      req_chan.mute_in    <= mute;
      req_chan.duck_delta <= delta;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic random_command();
      logic [2:0]         cmd;
      logic [3:0]         bus;
      logic signed [15:0] vol;
      logic signed [15:0] delta;
      logic               mute;
      int                 pick;
      pick  = $urandom_range(99);
      bus   = 4'($urandom_range(15));
      vol   = 16'($urandom);
      delta = 16'($urandom);
      mute  = 1'($urandom);
      if (pick < 30) begin
         cmd = hbgm_pkg::CMD_QUERY;
      end else if (pick < 52) begin
         cmd = hbgm_pkg::CMD_SET_VOLUME;
         if ($urandom_range(3) != 0) vol = 16'($urandom_range(8192));
      end else if (pick < 67) begin
         cmd = hbgm_pkg::CMD_SET_MUTE;
         mute = ($urandom_range(99) < 20);
      end else if (pick < 90) begin
         cmd = hbgm_pkg::CMD_ADD_DUCK;
         if ($urandom_range(7) != 0) delta = 16'(int'($urandom_range(4096)) - 2048);
      end else if (pick < 95) begin
         cmd = hbgm_pkg::CMD_CLEAR_DUCK;
      end else begin
         cmd = 3'($urandom_range(7, 5));
      end
      issue_command(cmd, bus, vol, mute, delta);
   endtask

   // hold the sender off until every report has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_vacuum(input logic mode);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      #5000000;
      $display("hierarchical_bus_gain_mixer: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.cmd = hbgm_pkg::CMD_QUERY;
      req_chan.bus = '0;
      req_chan.volume_in = '0;
      req_chan.mute_in = 1'b0;
      req_chan.duck_delta = '0;
      send_gap_pct = 0;
      take_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue_command(hbgm_pkg::CMD_QUERY, hbgm_pkg::BUS_MASTER, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd7, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_SET_VOLUME, 4'd15, 16'sd32767, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_SET_VOLUME, hbgm_pkg::BUS_AMBIENCE, 16'sd32767, 1'b0,
                    16'sd0);
      issue_command(hbgm_pkg::CMD_SET_VOLUME, hbgm_pkg::BUS_MASTER, 16'sd32767, 1'b1,
                    16'sd0);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd15, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_ADD_DUCK, hbgm_pkg::BUS_MASTER, 16'sd0, 1'b0,
                    -16'sd32768);
      issue_command(hbgm_pkg::CMD_ADD_DUCK, hbgm_pkg::BUS_MASTER, 16'sd0, 1'b0,
                    -16'sd32768);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd13, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_ADD_DUCK, 4'd9, 16'sd0, 1'b0, 16'sd32767);
      issue_command(hbgm_pkg::CMD_ADD_DUCK, 4'd9, 16'sd0, 1'b0, 16'sd32767);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd10, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_CLEAR_DUCK, 4'd10, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_SET_VOLUME, 4'd3, -16'sd1, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_SET_VOLUME, 4'd3, -16'sd32768, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_SET_VOLUME, hbgm_pkg::BUS_MASTER, 16'sd4096, 1'b0,
                    16'sd0);
      issue_command(hbgm_pkg::CMD_SET_MUTE, 4'd1, 16'sd0, 1'b1, 16'sd0);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd4, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_SET_MUTE, 4'd1, 16'sd0, 1'b0, 16'sd0);
      issue_command(CMD_SPARE_5, 4'd15, 16'sd100, 1'b1, 16'sd100);
      issue_command(CMD_SPARE_6, 4'd2, -16'sd1, 1'b1, -16'sd1);
      issue_command(CMD_SPARE_7, hbgm_pkg::BUS_MASTER, 16'sd0, 1'b0, 16'sd0);
      settle();
      write_vacuum(1'b1);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd2, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd14, 16'sd0, 1'b0, 16'sd0);
      issue_command(hbgm_pkg::CMD_QUERY, 4'd6, 16'sd0, 1'b0, 16'sd0);
      settle();
      write_vacuum(1'b0);

      for (int seg = 0; seg < 8; seg++) begin
         case (seg / 2)
            0: begin send_gap_pct = 0;  take_stall_pct = 0;  end
            1: begin send_gap_pct = 66; take_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  take_stall_pct = 66; end
            default: begin send_gap_pct = 8; take_stall_pct = 8; end
         endcase
         repeat (SEGMENT_ITEMS) random_command();
         settle();
         write_vacuum(1'((seg + 1) % 2));
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("hierarchical_bus_gain_mixer: match");
      end else begin
         $display("hierarchical_bus_gain_mixer: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/hbgm_pkg.sv
design/hbgm_if.sv
design/hbgm_store.sv
design/hbgm_hop_unit.sv
design/hierarchical_bus_gain_mixer.sv
tb/sv/hbgm_gain_checker.sv
tb/sv/tb_hierarchical_bus_gain_mixer.sv
